// File: rtl/i2c_master_bit_sequencer_top_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define I2CMS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("i2c sequencer check failed");

// Check that a condition implies another in the next cycle.
`define I2CMS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("i2c sequencer check failed");

`endif

// File: rtl/i2cms_pkg.sv
package i2cms_pkg;

  // Command codes carried on the input tuser field
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [15:0] DELAY_RESET = 16'd100;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  // Line sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_WR_LO   = 5'd5,
    PH_WR_HI   = 5'd6,
    PH_WR_TAIL = 5'd7,
    PH_AK_A    = 5'd8,
    PH_AK_B    = 5'd9,
    PH_AK_C    = 5'd10,
    PH_AK_D    = 5'd11,
    PH_RD_LO   = 5'd12,
    PH_RD_HI   = 5'd13,
    PH_RA_A    = 5'd14,
    PH_RA_B    = 5'd15
  } phase_t;

  // One result, packed in output tdata order from the top bit down to bit 0
  typedef struct packed {
    logic       no_ack;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       ready_res;
    logic       sda_drive;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage

// File: rtl/i2cms_core.sv
module i2cms_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [15:0]        delay_ticks,
  input  logic [2:0]         kind,
  input  logic [7:0]         tx_byte,
  input  logic               send_ack,
  input  logic               sda_in,
  output i2cms_pkg::result_t res
);
  import i2cms_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] wait_count, wait_count_next;
  logic        ack_mode, ack_mode_next;
  logic        ack_flag, ack_flag_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        sda_enable, sda_enable_next;
  logic [7:0]  rx_hold, rx_hold_next;

  logic [15:0] delay_eff;
  logic [15:0] wait_dec;
  logic [3:0]  bit_inc;
  logic        fin;

  assign delay_eff = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
  assign wait_dec  = wait_count - 16'd1;
  assign bit_inc   = bit_count + 4'd1;

  // Work out the state after this tick
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    ack_mode_next   = ack_mode;
    ack_flag_next   = ack_flag;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    sda_enable_next = sda_enable;
    rx_hold_next    = rx_hold;
    fin             = 1'b0;

    if (phase == PH_IDLE) begin
      // Take a new command
      case (kind)
        KIND_START: begin
          sda_enable_next = 1'b1;
          sda_level_next  = 1'b1;
          scl_level_next  = 1'b1;
          phase_next      = PH_ST_A;
          wait_count_next = delay_eff;
        end
        KIND_STOP: begin
          sda_enable_next = 1'b1;
          scl_level_next  = 1'b0;
          sda_level_next  = 1'b0;
          phase_next      = PH_SP_A;
          wait_count_next = delay_eff;
        end
        KIND_WRITE: begin
          sda_enable_next = 1'b1;
          scl_level_next  = 1'b0;
          bit_count_next  = 4'd0;
          sda_level_next  = tx_byte[7];
          shift_reg_next  = {tx_byte[6:0], 1'b0};
          phase_next      = PH_WR_LO;
          wait_count_next = delay_eff;
        end
        KIND_READ: begin
          sda_enable_next = 1'b0;
          sda_level_next  = 1'b1;
          scl_level_next  = 1'b0;
          bit_count_next  = 4'd0;
          shift_reg_next  = 8'd0;
          ack_mode_next   = send_ack;
          phase_next      = PH_RD_LO;
          wait_count_next = delay_eff;
        end
        default: ;
      endcase
    end else begin
      // Count down the delay step, then advance the line sequence
      wait_count_next = wait_dec;
      if (wait_dec == 16'd0) begin
        case (phase)
          PH_ST_A: begin
            sda_level_next  = 1'b0;
            phase_next      = PH_ST_B;
            wait_count_next = delay_eff;
          end
          PH_ST_B: begin
            scl_level_next = 1'b0;
            fin            = 1'b1;
          end
          PH_SP_A: begin
            scl_level_next  = 1'b1;
            sda_level_next  = 1'b1;
            phase_next      = PH_SP_B;
            wait_count_next = delay_eff;
          end
          PH_SP_B: fin = 1'b1;
          PH_WR_LO: begin
            scl_level_next  = 1'b1;
            phase_next      = PH_WR_HI;
            wait_count_next = delay_eff;
          end
          PH_WR_HI: begin
            scl_level_next  = 1'b0;
            phase_next      = PH_WR_TAIL;
            wait_count_next = delay_eff;
          end
          PH_WR_TAIL: begin
            bit_count_next  = bit_inc;
            wait_count_next = delay_eff;
            if (bit_inc < BITS_PER_BYTE) begin
              sda_level_next = shift_reg[7];
              shift_reg_next = {shift_reg[6:0], 1'b0};
              phase_next     = PH_WR_LO;
            end else begin
              phase_next = PH_AK_A;
            end
          end
          PH_AK_A: begin
            sda_level_next  = 1'b1;
            phase_next      = PH_AK_B;
            wait_count_next = delay_eff;
          end
          PH_AK_B: begin
            scl_level_next  = 1'b1;
            sda_enable_next = 1'b0;
            sda_level_next  = 1'b1;
            phase_next      = PH_AK_C;
            wait_count_next = delay_eff;
          end
          PH_AK_C: begin
            ack_flag_next   = sda_in;
            scl_level_next  = 1'b0;
            phase_next      = PH_AK_D;
            wait_count_next = delay_eff;
          end
          PH_AK_D: fin = 1'b1;
          PH_RD_LO: begin
            scl_level_next  = 1'b1;
            shift_reg_next  = {shift_reg[6:0], sda_in};
            phase_next      = PH_RD_HI;
            wait_count_next = delay_eff;
          end
          PH_RD_HI: begin
            bit_count_next  = bit_inc;
            scl_level_next  = 1'b0;
            wait_count_next = delay_eff;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_next = PH_RD_LO;
            end else begin
              rx_hold_next    = shift_reg;
              sda_enable_next = 1'b1;
              sda_level_next  = ~ack_mode;
              phase_next      = PH_RA_A;
            end
          end
          PH_RA_A: begin
            scl_level_next  = 1'b1;
            phase_next      = PH_RA_B;
            wait_count_next = delay_eff;
          end
          PH_RA_B: begin
            scl_level_next = 1'b0;
            fin            = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        // Drop back to idle when the command completes
        if (fin) begin
          phase_next      = PH_IDLE;
          wait_count_next = 16'd0;
        end
      end
    end
  end

  // Form the result from the updated state
  always_comb begin
    res.scl_out   = scl_level_next;
    res.sda_out   = sda_enable_next ? sda_level_next : 1'b1;
    res.sda_drive = sda_enable_next;
    res.ready_res = (phase_next == PH_IDLE);
    res.done_res  = fin;
    res.rx_byte   = rx_hold_next;
    res.no_ack    = ack_flag_next;
  end

  // Hold the state, advance it on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= 4'd0;
      shift_reg  <= 8'd0;
      wait_count <= 16'd0;
      ack_mode   <= 1'b0;
      ack_flag   <= 1'b0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      sda_enable <= 1'b1;
      rx_hold    <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      wait_count <= wait_count_next;
      ack_mode   <= ack_mode_next;
      ack_flag   <= ack_flag_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      sda_enable <= sda_enable_next;
      rx_hold    <= rx_hold_next;
    end
  end

endmodule

// File: rtl/i2cms_out_reg.sv
module i2cms_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  i2cms_pkg::result_t res,
  output logic               hold_free,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output i2cms_pkg::result_t m_res
);
  import i2cms_pkg::*;

  // Take a new request whenever the slot is empty or being drained
  assign hold_free = !m_axis_tvalid || m_axis_tready;

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

// File: rtl/i2c_master_bit_sequencer_top.sv
// I2C master line sequencer. Each request on the input stream is one clock
// tick of the line sequence; it may carry a command (tuser) that is taken only
// while the sequencer is idle, and it always carries the sampled SDA level.
// Every request yields exactly one result holding the SCL/SDA levels, the SDA
// drive enable, ready, a one-tick done flag, the last received byte and the
// last write acknowledge. A request is taken each cycle while the output slot
// is free or being drained; its result is registered and shows in the next
// cycle. Each line segment lasts cfg_wdata ticks (zero acts as one); the user
// writes it while the sequencer is idle, which the block does not enforce.
`include "i2c_master_bit_sequencer_top_defines.svh"

module i2c_master_bit_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tx_byte [7:0], send_ack [8], sda_in [9], zero [15:10]
  input  logic [15:0] s_axis_tdata,
  // kind [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_out [0], sda_out [1], sda_drive [2], ready_res [3], done_res [4],
  // rx_byte [12:5], no_ack [13], zero [15:14]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import i2cms_pkg::*;

  logic [15:0] delay_ticks;
  logic        step;
  result_t     res;
  result_t     m_res;

  // Hold the delay step register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks <= cfg_wdata;
    end
  end

  assign step = s_axis_tvalid && s_axis_tready;

  i2cms_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .delay_ticks (delay_ticks),
    .kind        (s_axis_tuser),
    .tx_byte     (s_axis_tdata[7:0]),
    .send_ack    (s_axis_tdata[8]),
    .sda_in      (s_axis_tdata[9]),
    .res         (res)
  );

  i2cms_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .res           (res),
    .hold_free     (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_res         (m_res)
  );

  assign m_axis_tdata = {2'b00, m_res};

  // Checks on the sequencer results
  `I2CMS_ASSERT_IMPLY(a_done_idle, clk, rst, m_axis_tvalid && m_res.done_res, m_res.ready_res)
  `I2CMS_ASSERT_IMPLY(a_release_high, clk, rst, m_axis_tvalid && !m_res.sda_drive, m_res.sda_out)
  `I2CMS_ASSERT_NEXT(a_request_result, clk, rst, step, m_axis_tvalid)

endmodule
